// ===== hdl/mse_pkg.sv =====
// ----------------------------------------------------------------------------
// mse_pkg: shared types and constants of the MIPS subset executor
// Field widths, opcodes and the word types passed between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

package mse_pkg;

   localparam int PROGRAM_WORDS = 128;
   localparam int DATA_WORDS    = 128;
   localparam int PROG_AW = $clog2(PROGRAM_WORDS);
   localparam int DATA_AW = $clog2(DATA_WORDS);
   localparam int PLEN_W  = $clog2(PROGRAM_WORDS + 1);
   localparam int QUEUE_DEPTH = 2;

   localparam logic [5:0] OP_RTYPE = 6'd0;
   localparam logic [5:0] OP_J     = 6'd2;
   localparam logic [5:0] OP_JAL   = 6'd3;
   localparam logic [5:0] OP_BEQ   = 6'd4;
   localparam logic [5:0] OP_BNE   = 6'd5;
   localparam logic [5:0] OP_ADDI  = 6'd8;
   localparam logic [5:0] OP_LW    = 6'd35;
   localparam logic [5:0] OP_SW    = 6'd43;

   localparam logic [5:0] FN_SLL = 6'd0;
   localparam logic [5:0] FN_ADD = 6'd32;
   localparam logic [5:0] FN_SUB = 6'd34;
   localparam logic [5:0] FN_AND = 6'd36;
   localparam logic [5:0] FN_OR  = 6'd37;
   localparam logic [5:0] FN_SLT = 6'd42;

   localparam logic [4:0] REG_SP = 5'd29;
   localparam logic [4:0] REG_RA = 5'd31;

   typedef struct packed {
      logic        mode;
      logic [31:0] instruction_word;
   } req_word_type;

   typedef struct packed {
      logic               load_accepted;
      logic               halted;
      logic        [31:0] executed_pc;
      logic        [31:0] next_pc;
      logic               reg_written;
      logic        [4:0]  reg_index;
      logic signed [31:0] reg_value;
      logic               mem_written;
      logic        [6:0]  mem_address;
      logic signed [31:0] mem_value;
   } rsp_word_type;

endpackage

`default_nettype wire

// ===== hdl/mse_channel_if.sv =====
// ----------------------------------------------------------------------------
// mse_req_if / mse_rsp_if: valid/ready channels of the executor
// One interface per channel direction type, each with source and sink views.
// ----------------------------------------------------------------------------
`default_nettype none

interface mse_req_if;
   import mse_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface mse_rsp_if;
   import mse_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/mse_front.sv =====
// ----------------------------------------------------------------------------
// mse_front: request classifier and queue
// Accepts request words into a short queue; the back end pops them.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_front
   import mse_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire req_word_type in_word,
   output logic              q_valid,
   output req_word_type      q_word,
   input  wire logic         q_pop
);

   localparam int QW = $clog2(QUEUE_DEPTH);

   req_word_type          slot_ff [QUEUE_DEPTH];
   logic [QW-1:0]         rd_ff, rd_in, wr_ff, wr_in;
   logic [QW:0]           cnt_ff, cnt_in;
   logic                  push;

   assign in_ready = (cnt_ff != (QW+1)'(QUEUE_DEPTH)) || q_pop;
   assign push     = in_valid && in_ready;
   assign q_valid  = cnt_ff != '0;
   assign q_word   = slot_ff[rd_ff];

   // pointer and count update
   always_comb begin
      rd_in  = rd_ff;
      wr_in  = wr_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in  = (wr_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         cnt_in = cnt_in + 1'b1;
      end
      if (q_pop) begin
         rd_in  = (rd_ff == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         cnt_in = cnt_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wr_ff] <= in_word;
   end

   pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QW+1)'(QUEUE_DEPTH)) else $error("queue overfilled");
   push_counts: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count lost a push");

endmodule

`default_nettype wire

// ===== hdl/mse_back.sv =====
// ----------------------------------------------------------------------------
// mse_back: instruction execution back end
// Holds pc, register file, program and data stores; one word per cycle
// while the output is not stalled, except lw, which waits for its data read.
// ----------------------------------------------------------------------------
`default_nettype none

// generic single-port-write RAM with registered read (old data on collision)
module mse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   assign rdata = rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end

endmodule

module mse_back
   import mse_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         q_valid,
   input  wire req_word_type q_word,
   output logic              q_pop,
   output logic              out_valid,
   input  wire logic         out_ready,
   output rsp_word_type      out_word
);

   logic [31:0]       pc_ff, pc_in, pc_next;
   logic [PLEN_W-1:0] plen_ff, plen_in;
   logic [31:0]       regs_ff [32];
   logic [DATA_WORDS-1:0] dvalid_ff;
   logic              ov_ff;
   logic              lw_busy_ff, lw_first;
   logic              byp_ff;
   logic [31:0]       byp_word_ff;
   rsp_word_type      ow_ff, r;

   logic [31:0] ins, prog_rdata, data_rdata, a, b, imm, seq, sum, rres, dval, wval;
   logic [5:0]  op, fn;
   logic [4:0]  rs, rt, rd, widx;
   logic [6:0]  addr;
   logic [DATA_AW-1:0] dix;
   logic [PROG_AW-1:0] prog_ra, prog_wa;
   logic        have, wen, men, prog_we, data_we;
   logic [31:0] pidx;

   // lw waits in lw_busy_ff for the registered data store read before it retires
   assign lw_first  = q_valid && q_word.mode && have && (op == OP_LW) && !lw_busy_ff;
   assign q_pop     = q_valid && !lw_first && (!ov_ff || out_ready);
   assign out_valid = ov_ff;
   assign out_word  = ow_ff;

   // program store: read ahead at the pc of the next cycle
   assign pc_next = q_pop ? pc_in : pc_ff;
   assign prog_ra = reset ? '0 : pc_next[PROG_AW+1:2];
   assign prog_wa = plen_ff[PROG_AW-1:0];
   assign prog_we = !reset && q_pop && !q_word.mode && r.load_accepted;
   assign data_we = !reset && q_pop && q_word.mode && have && men;

   mse_ram #(.WIDTH(32), .DEPTH(PROGRAM_WORDS)) u_prog_ram (
      .clock(clock), .we(prog_we), .waddr(prog_wa), .wdata(q_word.instruction_word),
      .raddr(prog_ra), .rdata(prog_rdata)
   );

   mse_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_data_ram (
      .clock(clock), .we(data_we), .waddr(dix), .wdata(b),
      .raddr(dix), .rdata(data_rdata)
   );

   // decode and execute
   always_comb begin
      pidx = {2'b00, pc_ff[31:2]};
      have = pidx < 32'(plen_ff);
      ins  = byp_ff ? byp_word_ff : prog_rdata;
      op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16];
      rd = ins[15:11]; fn = ins[5:0];
      a = (rs == 5'd0) ? '0 : regs_ff[rs];
      b = (rt == 5'd0) ? '0 : regs_ff[rt];
      imm = {{16{ins[15]}}, ins[15:0]};
      seq = pc_ff + 32'd4;
      sum = a + imm;
      addr = sum[6:0];
      dix  = DATA_AW'(addr);
      dval = dvalid_ff[dix] ? data_rdata : '0;
      rres = '0;
      case (fn)
         FN_ADD: rres = a + b;
         FN_SUB: rres = a - b;
         FN_AND: rres = a & b;
         FN_OR:  rres = a | b;
         FN_SLT: rres = {31'd0, $signed(a) < $signed(b)};
         FN_SLL: rres = b << ins[10:6];
         default: rres = '0;
      endcase
      wen = 1'b0; widx = '0; wval = '0; men = 1'b0;
      pc_in = pc_ff; plen_in = plen_ff;
      r = '0;
      if (!q_word.mode) begin
         if (plen_ff < PLEN_W'(PROGRAM_WORDS)) begin
            plen_in = plen_ff + 1'b1;
            r.load_accepted = 1'b1;
         end
      end else begin
         r.executed_pc = pc_ff;
         r.next_pc     = pc_ff;
         if (!have) begin
            r.halted = 1'b1;
         end else begin
            pc_in = seq;
            case (op)
               OP_RTYPE: begin
                  wen  = (fn == FN_ADD) || (fn == FN_SUB) || (fn == FN_AND) ||
                         (fn == FN_OR) || (fn == FN_SLT) || (fn == FN_SLL);
                  widx = rd; wval = rres;
               end
               OP_J:   pc_in = {4'd0, ins[25:0], 2'b00};
               OP_JAL: begin
                  pc_in = {4'd0, ins[25:0], 2'b00};
                  wen = 1'b1; widx = REG_RA; wval = seq;
               end
               OP_BEQ: if (a == b) pc_in = seq + {imm[29:0], 2'b00};
               OP_BNE: if (a != b) pc_in = seq + {imm[29:0], 2'b00};
               OP_ADDI: begin
                  wen = 1'b1; widx = rt; wval = sum;
               end
               OP_LW: begin
                  wen = 1'b1; widx = rt; wval = dval;
                  r.mem_address = addr; r.mem_value = dval;
               end
               OP_SW: begin
                  men = 1'b1;
                  r.mem_written = 1'b1; r.mem_address = addr; r.mem_value = b;
               end
               default: ;
            endcase
            if (widx == 5'd0 || widx == REG_SP) wen = 1'b0;
            r.reg_written = wen;
            r.reg_index   = wen ? widx : '0;
            r.reg_value   = wen ? wval : '0;
            r.next_pc     = pc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
         plen_ff <= '0;
         ov_ff <= 1'b0;
         lw_busy_ff <= 1'b0;
         dvalid_ff <= '0;
         for (int i = 0; i < 32; i++) regs_ff[i] <= '0;
      end else begin
         if (q_pop) begin
            pc_ff <= pc_in;
            plen_ff <= plen_in;
            ow_ff <= r;
            if (q_word.mode && have && wen) regs_ff[widx] <= wval;
            if (data_we) dvalid_ff[dix] <= 1'b1;
            lw_busy_ff <= 1'b0;
            ov_ff <= 1'b1;
         end else begin
            if (out_ready) ov_ff <= 1'b0;
            if (lw_first) lw_busy_ff <= 1'b1;
         end
      end
      // a load into the word being read ahead is forwarded for one cycle
      byp_ff      <= prog_we && (prog_wa == prog_ra);
      byp_word_ff <= q_word.instruction_word;
   end

   hold_out: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && !out_ready) |=> ov_ff && $stable(ow_ff))
      else $error("result dropped while stalled");
   no_sp_write: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && ow_ff.reg_written) |->
         ow_ff.reg_index != REG_SP && ow_ff.reg_index != 5'd0)
      else $error("write to protected register reported");
   halt_keeps_pc: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_word.mode && !have) |=> $stable(pc_ff))
      else $error("pc moved on halt");
   lw_waits: assert property (@(posedge clock) disable iff (reset)
      lw_first |=> lw_busy_ff)
      else $error("lw retired without its data read");

endmodule

`default_nettype wire

// ===== hdl/mips_subset_executor_core.sv =====
// ----------------------------------------------------------------------------
// mips_subset_executor_core: MIPS32 subset executor, top level
// Front queue feeding the execute back end.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: mode (0 = append word to program store, 1 = run one
//   instruction at pc) and instruction_word. rsp channel: one result word
//   per request word, in order.
//   Throughput: one word per cycle sustained while rsp.ready holds, except lw,
//   which holds the execute stage while the data store read completes.
//   Each instruction reads the pc and register file written by the word
//   before it. An accepted word passes the queue, then the registered result.
//   Reset (synchronous, active high) clears pc, program length, register
//   file and data store (the latter through per-word valid bits).
//   When the receiver stalls, the held result stays valid, the two-entry
//   queue fills, and req.ready drops; while the queue is full and a result is
//   held, req.ready follows rsp.ready in the same cycle, unless an lw waits.
// ----------------------------------------------------------------------------
`default_nettype none

module mips_subset_executor_core
   import mse_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   mse_req_if.sink   req,
   mse_rsp_if.source rsp
);

   logic         q_valid, q_pop;
   req_word_type q_word;

   mse_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_word(req.payload),
      .q_valid(q_valid), .q_word(q_word), .q_pop(q_pop)
   );

   mse_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_word(q_word), .q_pop(q_pop),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_word(rsp.payload)
   );

endmodule

`default_nettype wire

// ===== dv/mse_tb_channel_if.sv =====
// ----------------------------------------------------------------------------
// mse_tb_channel_if: testbench package mse_tb_pkg with the stimulus row type
// The block's own interfaces are used as they are; nothing is redefined here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mse_tb_pkg;
   import mse_pkg::*;

   // one row of the directed stimulus table
   typedef struct {
      logic         mode;
      logic [31:0]  word;
      bit           typed;
      rsp_word_type rsp;
   } stim_row_type;
endpackage

// ===== dv/mips_subset_executor_core_tb.sv =====
// ----------------------------------------------------------------------------
// mips_subset_executor_core_tb: self-checking bench of the MIPS subset executor
// Loads short programs, runs them step by step and checks every result word
// against an in-bench model of the executor; both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mips_subset_executor_core_tb;
   import mse_pkg::*;
   import mse_tb_pkg::*;

   // R-type function code outside the supported set (jr)
   localparam logic [5:0] FN_JR = 6'd8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mse_req_if req ();
   mse_rsp_if rsp ();

   mips_subset_executor_core u_top (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // model state of the executor
   logic [31:0] pc_q;
   int unsigned prog_len;
   logic [31:0] prog_mem [PROGRAM_WORDS];
   logic [31:0] regs [32];
   logic [31:0] dmem [DATA_WORDS];

   rsp_word_type pending_rsp [$];
   int unsigned  n_fail = 0;
   int unsigned  n_checked = 0;
   int unsigned  n_halted = 0;
   bit           no_idle = 1'b0;
   int unsigned  hold_cycles = 0;

   function automatic void model_reset();
      pc_q = '0;
      prog_len = 0;
      for (int i = 0; i < 32; i++) regs[i] = '0;
      for (int i = 0; i < DATA_WORDS; i++) dmem[i] = '0;
   endfunction

   function automatic void reg_write(inout rsp_word_type r, input logic [4:0] idx,
                                     input logic [31:0] val);
      if (idx != 5'd0 && idx != REG_SP) begin
         regs[idx] = val;
         r.reg_written = 1'b1;
         r.reg_index = idx;
         r.reg_value = val;
      end
   endfunction

   // compute one step of the executor
   function automatic rsp_word_type exec_step(logic mode, logic [31:0] word);
      rsp_word_type r;
      logic [31:0] ins, a, b, imm, seq, nxt, res;
      logic [5:0]  op, fn;
      logic [4:0]  rs, rt, rd, sh;
      logic [6:0]  addr;
      bit          ok;
      r = '0;
      if (mode == 1'b0) begin
         if (prog_len < PROGRAM_WORDS) begin
            prog_mem[prog_len] = word;
            prog_len++;
            r.load_accepted = 1'b1;
         end
         return r;
      end
      r.executed_pc = pc_q;
      if ((pc_q >> 2) >= prog_len) begin
         r.halted = 1'b1;
         r.next_pc = pc_q;
         return r;
      end
      ins = prog_mem[pc_q >> 2];
      op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16];
      rd = ins[15:11]; sh = ins[10:6];  fn = ins[5:0];
      a = regs[rs]; b = regs[rt];
      imm = {{16{ins[15]}}, ins[15:0]};
      seq = pc_q + 32'd4;
      nxt = seq;
      case (op)
         OP_RTYPE: begin
            ok = 1'b1;
            case (fn)
               FN_ADD: res = a + b;
               FN_SUB: res = a - b;
               FN_AND: res = a & b;
               FN_OR:  res = a | b;
               FN_SLT: res = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
               FN_SLL: res = b << sh;
               default: ok = 1'b0;
            endcase
            if (ok) reg_write(r, rd, res);
         end
         OP_J:   nxt = {4'd0, ins[25:0], 2'b00};
         OP_JAL: begin
            reg_write(r, REG_RA, seq);
            nxt = {4'd0, ins[25:0], 2'b00};
         end
         OP_BEQ: if (a == b) nxt = seq + (imm << 2);
         OP_BNE: if (a != b) nxt = seq + (imm << 2);
         OP_ADDI: reg_write(r, rt, a + imm);
         OP_LW: begin
            res = a + imm;
            addr = res[6:0];
            r.mem_address = addr;
            r.mem_value = dmem[addr];
            reg_write(r, rt, dmem[addr]);
         end
         OP_SW: begin
            res = a + imm;
            addr = res[6:0];
            dmem[addr] = b;
            r.mem_written = 1'b1;
            r.mem_address = addr;
            r.mem_value = b;
         end
         default: ;
      endcase
      pc_q = nxt;
      r.next_pc = nxt;
      return r;
   endfunction

   // instruction builders
   function automatic logic [31:0] r_ins(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                         logic [4:0] rd, logic [4:0] sh);
      return {OP_RTYPE, rs, rt, rd, sh, fn};
   endfunction
   function automatic logic [31:0] i_ins(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic logic [31:0] rand_ins();
      logic [5:0] ops [8] = '{OP_RTYPE, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDI, OP_LW, OP_SW};
      logic [5:0] fns [6] = '{FN_SLL, FN_ADD, FN_SUB, FN_AND, FN_OR, FN_SLT};
      logic [31:0] w;
      int unsigned k;
      w = $urandom();
      k = $urandom_range(0, 99);
      if (k < 5) return w;   // noise: arbitrary word
      w[31:26] = ops[$urandom_range(0, 7)];
      if (w[31:26] == OP_RTYPE) w[5:0] = fns[$urandom_range(0, 5)];
      // keep branches and jumps mostly inside a short program
      if (w[31:26] == OP_J || w[31:26] == OP_JAL)
         w[25:0] = (k < 15) ? w[25:0] : 26'($urandom_range(0, 40));
      if ((w[31:26] == OP_BEQ || w[31:26] == OP_BNE) && k >= 15)
         w[15:0] = 16'($signed($urandom_range(0, 6)) - 3);
      return w;
   endfunction

   // driver of the request channel; valid stays up between back-to-back words
   task automatic send_word(logic mode, logic [31:0] word);
      if (!no_idle && $urandom_range(0, 99) < 33) begin
         req.valid <= 1'b0;
         @(posedge clock);
         while (!no_idle && $urandom_range(0, 99) < 33) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.payload <= '{mode: mode, instruction_word: word};
      pending_rsp.push_back(exec_step(mode, word));
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic check_word(rsp_word_type got, rsp_word_type exp);
      if (got.load_accepted !== exp.load_accepted) begin
         $error("load_accepted exp %0d got %0d", exp.load_accepted, got.load_accepted);
         n_fail++;
      end
      if (got.halted !== exp.halted) begin
         $error("halted exp %0d got %0d", exp.halted, got.halted); n_fail++;
      end
      if (got.executed_pc !== exp.executed_pc) begin
         $error("executed_pc exp %h got %h", exp.executed_pc, got.executed_pc); n_fail++;
      end
      if (got.next_pc !== exp.next_pc) begin
         $error("next_pc exp %h got %h", exp.next_pc, got.next_pc); n_fail++;
      end
      if (got.reg_written !== exp.reg_written) begin
         $error("reg_written exp %0d got %0d", exp.reg_written, got.reg_written); n_fail++;
      end
      if (got.reg_index !== exp.reg_index) begin
         $error("reg_index exp %0d got %0d", exp.reg_index, got.reg_index); n_fail++;
      end
      if (got.reg_value !== exp.reg_value) begin
         $error("reg_value exp %h got %h", exp.reg_value, got.reg_value); n_fail++;
      end
      if (got.mem_written !== exp.mem_written) begin
         $error("mem_written exp %0d got %0d", exp.mem_written, got.mem_written); n_fail++;
      end
      if (got.mem_address !== exp.mem_address) begin
         $error("mem_address exp %0d got %0d", exp.mem_address, got.mem_address); n_fail++;
      end
      if (got.mem_value !== exp.mem_value) begin
         $error("mem_value exp %h got %h", exp.mem_value, got.mem_value); n_fail++;
      end
   endtask

   // result monitor: compare each accepted word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_rsp.size() == 0) begin
            $error("result word with nothing expected");
            n_fail++;
         end else begin
            check_word(rsp.payload, pending_rsp.pop_front());
            n_checked++;
            if (rsp.payload.halted) n_halted++;
         end
      end
   end

   // receiver: random stalls, one long hold-off while the sender keeps going
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= no_idle || ($urandom_range(0, 99) >= 33);
      end
   end

   initial begin
      stim_row_type rows [$];
      rsp_word_type z;
      rsp_word_type got_exp;
      int unsigned  n_items;
      z = '0;
      req.valid = 1'b0;
      req.payload = '0;
      rsp.ready = 1'b0;
      model_reset();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: halt on empty store, then a program touching every op
      got_exp = z; got_exp.halted = 1'b1;
      rows.push_back('{1'b1, 32'hffff_ffff, 1'b1, got_exp});
      got_exp = z; got_exp.load_accepted = 1'b1;
      rows.push_back('{1'b0, i_ins(OP_ADDI, 5'd0, 5'd1, 16'h7fff), 1'b1, got_exp});
      rows.push_back('{1'b0, i_ins(OP_ADDI, 5'd0, 5'd2, 16'h8000), 1'b1, got_exp});
      rows.push_back('{1'b0, i_ins(OP_ADDI, 5'd0, 5'd29, 16'h0005), 1'b1, got_exp});
      rows.push_back('{1'b0, i_ins(OP_ADDI, 5'd0, 5'd0, 16'h0005), 1'b1, got_exp});
      rows.push_back('{1'b0, r_ins(FN_ADD, 5'd1, 5'd2, 5'd3, 5'd0), 1'b0, z});
      rows.push_back('{1'b0, r_ins(FN_SUB, 5'd2, 5'd1, 5'd4, 5'd0), 1'b0, z});
      rows.push_back('{1'b0, r_ins(FN_AND, 5'd1, 5'd2, 5'd5, 5'd0), 1'b0, z});
      rows.push_back('{1'b0, r_ins(FN_OR,  5'd1, 5'd2, 5'd6, 5'd0), 1'b0, z});
      rows.push_back('{1'b0, r_ins(FN_SLT, 5'd2, 5'd1, 5'd7, 5'd0), 1'b0, z});
      rows.push_back('{1'b0, r_ins(FN_SLL, 5'd0, 5'd1, 5'd8, 5'd31), 1'b0, z});
      rows.push_back('{1'b0, r_ins(FN_JR, 5'd31, 5'd0, 5'd0, 5'd0), 1'b0, z});
      rows.push_back('{1'b0, i_ins(OP_SW, 5'd1, 5'd2, 16'hffff), 1'b0, z});
      rows.push_back('{1'b0, i_ins(OP_LW, 5'd1, 5'd9, 16'hffff), 1'b0, z});
      rows.push_back('{1'b0, i_ins(OP_BEQ, 5'd1, 5'd1, 16'h0001), 1'b0, z});
      rows.push_back('{1'b0, 32'hffff_ffff, 1'b0, z});
      rows.push_back('{1'b0, i_ins(OP_BNE, 5'd1, 5'd2, 16'h0001), 1'b0, z});
      rows.push_back('{1'b0, 32'h0000_0000, 1'b0, z});
      rows.push_back('{1'b0, {OP_JAL, 26'd19}, 1'b0, z});
      rows.push_back('{1'b0, {OP_J, 26'd20}, 1'b0, z});
      for (int i = 0; i < 21; i++) rows.push_back('{1'b1, $urandom(), 1'b0, z});

      foreach (rows[i]) begin
         send_word(rows[i].mode, rows[i].word);
         if (rows[i].typed) pending_rsp[$] = rows[i].rsp;
      end

      // random programs: load, run, then fill the store once to overflow
      n_items = rows.size();
      for (int p = 0; n_items < 1750; p++) begin
         int unsigned len;
         req.valid <= 1'b0;
         while (pending_rsp.size() != 0) @(posedge clock);
         repeat (4) @(posedge clock);
         no_idle = (p == 3);
         if (p == 5) hold_cycles = 60;
         if (prog_len > 100 || p == 8) begin
            // fill the program store completely, then send words that it refuses
            while (prog_len < PROGRAM_WORDS + 2) begin
               send_word(1'b0, rand_ins());
               n_items++;
               if (prog_len == PROGRAM_WORDS) break;
            end
            for (int k = 0; k < 3; k++) begin
               send_word(1'b0, $urandom());
               n_items++;
            end
         end else begin
            len = $urandom_range(3, 20);
            for (int k = 0; k < len; k++) begin
               send_word(1'b0, rand_ins());
               n_items++;
            end
         end
         for (int k = 0; k < 40; k++) begin
            send_word($urandom_range(0, 19) != 0, $urandom());
            n_items++;
         end
      end
      req.valid <= 1'b0;
      no_idle = 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("checked %0d result words (%0d halted steps), program store filled %0d",
               n_checked, n_halted, prog_len);
      if (n_fail == 0) begin
         $display("mips_subset_executor_core verification clean");
      end else begin
         $display("mips_subset_executor_core verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("mips_subset_executor_core verification failed");
      $finish;
   end

endmodule
